// ----- rtl/mtb_pkg.sv -----
package mtb_pkg;

    localparam int TIMER_COUNT_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_W           = 32;
    localparam int ID_W            = 8;
    localparam int CMD_W           = 3;
    localparam int RES_W           = $clog2(MAX_RESULTS + 1);

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NOTIFY = 3'd5;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic              tick;
        logic              wr;
        logic              shift;
        logic [CMD_W-1:0]  cmd;
        logic [CNT_W-1:0]  count;
        logic              periodic;
        logic              notify;
    } t_cell_cmd;

endpackage

// ----- rtl/mtb_cell.sv -----
module mtb_cell
    import mtb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  logic      i_sel,
    input  logic      i_pend,
    input  logic      i_any,
    output logic      o_pend,
    output logic      o_any,
    output logic      o_flag
);

    logic [CNT_W-1:0] r_ctr, n_ctr;
    logic [CNT_W-1:0] r_period, n_period;
    logic             r_flag, n_flag;
    logic             r_notify, n_notify;
    logic             r_pend, n_pend;

    always_comb begin
        n_ctr    = r_ctr;
        n_period = r_period;
        n_flag   = r_flag;
        n_notify = r_notify;
        n_pend   = r_pend;
        if (i_cmd.tick) begin
            n_pend = 1'b0;
            if (r_ctr != '0) begin
                if (r_ctr == CNT_W'(1)) begin
                    n_flag = 1'b1;
                    n_ctr  = r_period;
                    n_pend = r_notify;
                end else begin
                    n_ctr = r_ctr - CNT_W'(1);
                end
            end
        end else if (i_cmd.shift) begin
            n_pend = i_pend;
        end
        if (i_cmd.wr && i_sel) begin
            unique case (i_cmd.cmd)
                CMD_SET: begin
                    n_ctr = i_cmd.count;
                    if (i_cmd.periodic) begin
                        n_period = i_cmd.count;
                    end
                end
                CMD_STOP: begin
                    n_ctr    = '0;
                    n_period = '0;
                    n_flag   = 1'b0;
                end
                CMD_CLEAR:  n_flag   = 1'b0;
                CMD_NOTIFY: n_notify = i_cmd.notify;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr    <= '0;
            r_period <= '0;
            r_flag   <= 1'b0;
            r_notify <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_ctr    <= n_ctr;
            r_period <= n_period;
            r_flag   <= n_flag;
            r_notify <= n_notify;
            r_pend   <= n_pend;
        end
    end

    assign o_pend = r_pend;
    assign o_any  = r_pend | i_any;
    assign o_flag = r_flag;

endmodule

// ----- rtl/multi_timer_bank.sv -----
// Bank of TIMER_COUNT down-counting timers, one cell per timer. A command other
// than tick is taken and gives one registered result. A tick updates all
// timers in the cycle it is accepted; expiry events then leave one per cycle,
// while the output is not stalled, as a chain of pending bits shifts down the
// row of cells. The scan ends right after the highest notified expiry, or
// earlier once MAX_RESULTS events have left.
// New input is taken only when the block is idle and the output register is
// free or being emptied in the same cycle.
module multi_timer_bank
    import mtb_pkg::*;
#(
    parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // timer_id, count, periodic, notify_enable
    input  logic [2:0]  i_s_tuser,  // cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // status, event_timer, fired, overflow_flag
    output logic        o_m_tlast
);

    localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    t_state r_state, n_state;

    logic [IW-1:0]    r_idx;
    logic [RES_W-1:0] r_n;

    logic             r_m_valid;
    logic             r_status;
    logic [ID_W-1:0]  r_event;
    logic             r_fired;
    logic             r_oflag;
    logic             r_last;

    logic [CMD_W-1:0] in_cmd;
    logic [ID_W-1:0]  in_id;
    logic             accept;
    logic             out_free;
    logic             id_ok;
    logic             cmd_ok;
    logic             is_tick;
    t_cell_cmd        cell_cmd;

    logic [TIMER_COUNT-1:0] pend;
    logic [TIMER_COUNT-1:0] any;
    logic [TIMER_COUNT-1:0] flags;
    logic                   rest;

    logic             ready;
    logic             shift;
    logic             load;
    logic             done;
    logic             ld_status;
    logic [ID_W-1:0]  ld_event;
    logic             ld_fired;
    logic             ld_oflag;
    logic             ld_last;

    assign in_cmd   = i_s_tuser;
    assign in_id    = i_s_tdata[7:0];
    assign accept   = i_s_tvalid && ready;
    assign out_free = !r_m_valid || i_m_tready;
    assign id_ok    = {1'b0, in_id} < 9'(TIMER_COUNT);
    assign cmd_ok   = in_cmd <= CMD_NOTIFY;
    assign is_tick  = in_cmd == CMD_TICK;

    assign cell_cmd.tick     = accept && is_tick;
    assign cell_cmd.wr       = accept && !is_tick && cmd_ok && id_ok;
    assign cell_cmd.shift    = shift;
    assign cell_cmd.cmd      = in_cmd;
    assign cell_cmd.count    = i_s_tdata[39:8];
    assign cell_cmd.periodic = i_s_tdata[40];
    assign cell_cmd.notify   = i_s_tdata[41];

    for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_cell
        logic pend_up;
        logic any_up;
        if (g == TIMER_COUNT - 1) begin : g_end
            assign pend_up = 1'b0;
            assign any_up  = 1'b0;
        end else begin : g_mid
            assign pend_up = pend[g+1];
            assign any_up  = any[g+1];
        end
        mtb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cell_cmd),
            .i_sel   (in_id == ID_W'(g)),
            .i_pend  (pend_up),
            .i_any   (any_up),
            .o_pend  (pend[g]),
            .o_any   (any[g]),
            .o_flag  (flags[g])
        );
    end

    assign rest = (TIMER_COUNT > 1) ? any[TIMER_COUNT > 1 ? 1 : 0] : 1'b0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && is_tick) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (out_free && done) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        ready     = 1'b0;
        shift     = 1'b0;
        load      = 1'b0;
        done      = 1'b0;
        ld_status = 1'b0;
        ld_event  = '0;
        ld_fired  = 1'b0;
        ld_oflag  = 1'b0;
        ld_last   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                ready = out_free;
                if (accept && !is_tick) begin
                    load      = 1'b1;
                    ld_status = !(cmd_ok && id_ok);
                    ld_event  = in_id;
                    ld_oflag  = (in_cmd == CMD_QUERY) && id_ok && flags[in_id[IW-1:0]];
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    shift = 1'b1;
                    if (pend[0]) begin
                        load     = 1'b1;
                        ld_event = ID_W'(r_idx);
                        ld_fired = 1'b1;
                        ld_last  = !rest || (r_n == RES_W'(MAX_RESULTS - 1));
                        done     = ld_last;
                    end else if (!rest) begin
                        load = r_n == '0;
                        done = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_idx     <= '0;
            r_n       <= '0;
        end else begin
            r_state <= n_state;
            if (out_free) begin
                r_m_valid <= load;
            end
            if (accept) begin
                r_idx <= '0;
                r_n   <= '0;
            end else if (shift) begin
                r_idx <= r_idx + IW'(1);
                if (load && ld_fired) begin
                    r_n <= r_n + RES_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= ld_status;
            r_event  <= ld_event;
            r_fired  <= ld_fired;
            r_oflag  <= ld_oflag;
            r_last   <= ld_last;
        end
    end

    assign o_s_tready = ready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'b0, r_oflag, r_fired, r_event, r_status};
    assign o_m_tlast  = r_last;

`ifndef ASSERT_OFF
    a_no_take_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> !o_s_tready)
        else $error("input taken during event scan");

    a_event_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RES_W'(MAX_RESULTS))
        else $error("too many events in one tick");

    a_event_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[9] |-> !o_m_tdata[0])
        else $error("event carries error status");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !is_tick |=> o_m_tvalid && o_m_tlast && r_state == ST_IDLE)
        else $error("command result missing");
`endif

endmodule
